### rtl/core/pscr_pkg.sv
// ----------------------------------------------------------------------------
// pscr_pkg
// Types and fixed codes shared by the pad serial read controller.
// ----------------------------------------------------------------------------
package pscr_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  localparam logic [1:0] KIND_SAMPLE = 2'd3;

  // Bus register addresses
  localparam logic [7:0] ADDR_LOW  = 8'h10;
  localparam logic [7:0] ADDR_HIGH = 8'h14;
  localparam logic [7:0] ADDR_CTL  = 8'h28;

  // Control register bits
  localparam int unsigned CTL_ABORT_BIT   = 0;
  localparam int unsigned CTL_BUSY_BIT    = 1;
  localparam int unsigned CTL_START_BIT   = 2;
  localparam int unsigned CTL_INHIBIT_BIT = 7;
  localparam logic [7:0]  CTL_KEEP        = 8'hB1;
  localparam logic [7:0]  CTL_FIXED       = 8'h4C;

  // Configuration register indexes
  localparam logic CFG_INSTANT_READ = 1'b0;
  localparam logic CFG_BIT_PERIOD   = 1'b1;

  // Configuration reset values
  localparam logic [9:0] BIT_PERIOD_RESET   = 10'd640;
  localparam logic       INSTANT_READ_RESET = 1'b1;

  // Number of bits in one serial read
  localparam logic [4:0] SERIAL_BITS = 5'd16;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       interrupt_line;
    logic       serial_busy;
  } result_t;

endpackage

### rtl/core/pscr_engine.sv
// ----------------------------------------------------------------------------
// pscr_engine
// Register state of the pad interface; applies one item per transfer and
// forms its result in the same cycle.
// ----------------------------------------------------------------------------
module pscr_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           kind,
  input  logic [7:0]           address,
  input  logic [7:0]           write_data,
  input  logic [13:0]          pad_buttons,
  input  logic                 pad_status_bit,
  input  logic                 instant_read,
  input  logic [9:0]           bit_period,
  output pscr_pkg::result_t    result
);

  logic [15:0] pad_sample,     pad_sample_next;
  logic [15:0] latched_sample, latched_sample_next;
  logic [15:0] shift_data,     shift_data_next;
  logic [7:0]  control_bits,   control_bits_next;
  logic [4:0]  bit_index,      bit_index_next;
  logic [9:0]  countdown,      countdown_next;
  logic        irq_pending,    irq_pending_next;

  logic [9:0]  period_ticks;
  logic [9:0]  count_dec;
  logic [4:0]  index_inc;
  logic [15:0] view;
  logic [7:0]  rd;

  // A zero period counts as one tick
  assign period_ticks = (bit_period == 10'd0) ? 10'd1 : bit_period;
  assign count_dec    = countdown - 10'd1;
  assign index_inc    = bit_index + 5'd1;
  assign view         = instant_read ? pad_sample : shift_data;

  // Next state and read data for the item on the input
  always_comb begin
    pad_sample_next     = pad_sample;
    latched_sample_next = latched_sample;
    shift_data_next     = shift_data;
    control_bits_next   = control_bits;
    bit_index_next      = bit_index;
    countdown_next      = countdown;
    irq_pending_next    = irq_pending;
    rd                  = 8'h00;
    case (kind)
      pscr_pkg::KIND_TICK: begin
        if (countdown != 10'd0) begin
          countdown_next = count_dec;
          if (count_dec == 10'd0) begin
            shift_data_next[bit_index[3:0]] = latched_sample[bit_index[3:0]];
            bit_index_next = index_inc;
            if (index_inc < pscr_pkg::SERIAL_BITS) begin
              countdown_next = period_ticks;
            end else if (!control_bits[pscr_pkg::CTL_INHIBIT_BIT]) begin
              irq_pending_next = 1'b1;
            end
          end
        end
      end
      pscr_pkg::KIND_READ: begin
        case (address)
          pscr_pkg::ADDR_LOW:  rd = view[7:0];
          pscr_pkg::ADDR_HIGH: rd = view[15:8];
          pscr_pkg::ADDR_CTL: begin
            rd = control_bits | pscr_pkg::CTL_FIXED;
            rd[pscr_pkg::CTL_BUSY_BIT] = (countdown != 10'd0);
          end
          default: rd = 8'h00;
        endcase
      end
      pscr_pkg::KIND_WRITE: begin
        if (address == pscr_pkg::ADDR_CTL) begin
          // Start only from idle with abort-disable clear beforehand
          if (write_data[pscr_pkg::CTL_START_BIT] &&
              !control_bits[pscr_pkg::CTL_ABORT_BIT] && countdown == 10'd0) begin
            latched_sample_next = pad_sample;
            bit_index_next      = 5'd0;
            countdown_next      = period_ticks;
          end
          // Abort wins over a start in the same write
          if (write_data[pscr_pkg::CTL_ABORT_BIT]) begin
            countdown_next = 10'd0;
            bit_index_next = 5'd0;
          end
          if (write_data[pscr_pkg::CTL_INHIBIT_BIT]) begin
            irq_pending_next = 1'b0;
          end
          control_bits_next = write_data & pscr_pkg::CTL_KEEP;
        end
      end
      default: begin
        pad_sample_next = {pad_buttons, 1'b1, pad_status_bit};
      end
    endcase
  end

  // Result reflects the state after this item
  always_comb begin
    result.read_data      = rd;
    result.interrupt_line = irq_pending_next;
    result.serial_busy    = (countdown_next != 10'd0);
  end

  // Commit state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_sample     <= 16'h0000;
      latched_sample <= 16'h0000;
      shift_data     <= 16'h0000;
      control_bits   <= 8'h00;
      bit_index      <= 5'd0;
      countdown      <= 10'd0;
      irq_pending    <= 1'b0;
    end else if (fire) begin
      pad_sample     <= pad_sample_next;
      latched_sample <= latched_sample_next;
      shift_data     <= shift_data_next;
      control_bits   <= control_bits_next;
      bit_index      <= bit_index_next;
      countdown      <= countdown_next;
      irq_pending    <= irq_pending_next;
    end
  end

`ifndef SYNTH
  // A running read never points past the last bit
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (countdown != 10'd0) |-> (bit_index < pscr_pkg::SERIAL_BITS))
    else $error("bit index out of range while busy");

  // The interrupt rises only on a tick
  a_irq_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_pending) |-> $past(fire && kind == pscr_pkg::KIND_TICK))
    else $error("interrupt raised by a non-tick item");

  // An inhibit write clears the interrupt
  a_inhibit_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && kind == pscr_pkg::KIND_WRITE && address == pscr_pkg::ADDR_CTL &&
     write_data[pscr_pkg::CTL_INHIBIT_BIT]) |=> !irq_pending)
    else $error("interrupt survived an inhibit write");
`endif

endmodule

### rtl/core/pscr_skid.sv
// ----------------------------------------------------------------------------
// pscr_skid
// Two-entry output register: holds a result plus one spare so the input
// side can place one more result while the consumer stalls.
// ----------------------------------------------------------------------------
module pscr_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pscr_pkg::result_t  push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output pscr_pkg::result_t  out_data
);

  logic              skid_valid;
  pscr_pkg::result_t skid_data;
  logic              pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // Advance the output, refill from the spare, or park a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  // The spare is only ever filled behind a held output
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("spare entry full with output empty");
`endif

endmodule

### rtl/core/pad_serial_read_controller_core.sv
// ----------------------------------------------------------------------------
// pad_serial_read_controller_core
// Game-pad serial read controller behind byte-wide bus registers.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | in_valid / in_ready  | kind, address, write_data,
//            |                      | pad_buttons, pad_status_bit
//   result   | out_valid / out_ready| read_data, interrupt_line, serial_busy
//   config   | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while in_ready is high: the state update is a single
// pass from the input ports into the state registers, and each result is
// registered in the two-entry output register, which lets the input accept
// one more item while the output stalls; in_ready drops only when both
// entries are full. Reset (rst, synchronous) clears all state and sets
// instant_read to 1 and bit_period to 640.
// ----------------------------------------------------------------------------
module pad_serial_read_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  address,
  input  logic [7:0]  write_data,
  input  logic [13:0] pad_buttons,
  input  logic        pad_status_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        interrupt_line,
  output logic        serial_busy,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  logic              instant_read;
  logic [9:0]        bit_period;
  logic              fire;
  logic              space;
  pscr_pkg::result_t result;
  pscr_pkg::result_t out_data;

  assign in_ready = space;
  assign fire     = in_valid && space;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      instant_read <= pscr_pkg::INSTANT_READ_RESET;
      bit_period   <= pscr_pkg::BIT_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pscr_pkg::CFG_INSTANT_READ: instant_read <= cfg_data[0];
        pscr_pkg::CFG_BIT_PERIOD:   bit_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  pscr_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .kind           (kind),
    .address        (address),
    .write_data     (write_data),
    .pad_buttons    (pad_buttons),
    .pad_status_bit (pad_status_bit),
    .instant_read   (instant_read),
    .bit_period     (bit_period),
    .result         (result)
  );

  pscr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign read_data      = out_data.read_data;
  assign interrupt_line = out_data.interrupt_line;
  assign serial_busy    = out_data.serial_busy;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pad serial read controller core: a directed
// table of bus, tick and sample items, then random serial reads and noise
// under several register settings, checked against the table's expected
// results or an in-bench predictor of the controller.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_AT        = 600;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int          LONG_TICKS     = 150;

  // One input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  address;
    logic [7:0]  write_data;
    logic [13:0] pad_buttons;
    logic        pad_status_bit;
  } pad_item_t;

  // Directed row; a register row takes instant_read from the status field
  // and bit_period from the low ten button bits
  typedef struct packed {
    logic              is_cfg;
    logic [7:0]        reps;
    pad_item_t         item;
    logic              typed;
    pscr_pkg::result_t want;
  } stim_row_t;

  typedef struct packed {
    logic        instant;
    logic [9:0]  period;
    logic        quiet;
    logic [11:0] count;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  address;
  logic [7:0]  write_data;
  logic [13:0] pad_buttons;
  logic        pad_status_bit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic        interrupt_line;
  logic        serial_busy;
  logic        cfg_we;
  logic        cfg_index;
  logic [9:0]  cfg_data;

  // Predictor state and register copies
  logic [15:0] pad_live;
  logic [15:0] pad_latched;
  logic [15:0] shift_word;
  logic [7:0]  ctl_word;
  logic [4:0]  bit_pos;
  logic [9:0]  tick_count;
  logic        irq_level;
  logic        cfg_instant;
  logic [9:0]  cfg_period;

  pscr_pkg::result_t pending_results [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          quiet_run;
  bit          rx_hold_done;

  stim_row_t dir_tab [22] = '{
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   pscr_pkg::ADDR_CTL,  8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h4C, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   pscr_pkg::ADDR_LOW,  8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_TICK,   8'h00,               8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_SAMPLE, 8'h00,               8'h00, 14'h3FFF, 1'b1},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   pscr_pkg::ADDR_LOW,  8'h00, 14'h0000, 1'b0},
      1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   8'hFF,               8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    // start written to the wrong address does nothing
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_LOW,  8'h04, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h04, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b1}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   pscr_pkg::ADDR_CTL,  8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h4E, 1'b0, 1'b1}},
    // start while busy is dropped, abort stops the read
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h05, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    // abort-disable still set: start is dropped
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h04, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    // shifted data, zero bit period
    '{1'b1, 8'd1, '{pscr_pkg::KIND_TICK,   8'h00,               8'h00, 14'h0000, 1'b0},
      1'b0, '{8'h00, 1'b0, 1'b0}},
    // start and abort in one write: abort wins
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h05, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_SAMPLE, 8'h00,               8'h00, 14'h2AAA, 1'b1},
      1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h04, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b1}},
    // new sample during the read must not reach the latched copy
    '{1'b0, 8'd1, '{pscr_pkg::KIND_SAMPLE, 8'h00,               8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b1}},
    '{1'b0, 8'd15, '{pscr_pkg::KIND_TICK,  8'h00,               8'h00, 14'h0000, 1'b0},
      1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_TICK,   8'h00,               8'h00, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b1, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   pscr_pkg::ADDR_LOW,  8'h00, 14'h0000, 1'b0},
      1'b1, '{8'hAB, 1'b1, 1'b0}},
    '{1'b0, 8'd1, '{pscr_pkg::KIND_READ,   pscr_pkg::ADDR_HIGH, 8'h00, 14'h0000, 1'b0},
      1'b1, '{8'hAA, 1'b1, 1'b0}},
    // inhibit clears the pending interrupt
    '{1'b0, 8'd1, '{pscr_pkg::KIND_WRITE,  pscr_pkg::ADDR_CTL,  8'h80, 14'h0000, 1'b0},
      1'b1, '{8'h00, 1'b0, 1'b0}}
  };

  // instant, period, no idling, item count at which the phase ends
  phase_t phases [7] = '{
    '{1'b0, 10'd1,    1'b0, 12'd180},
    '{1'b1, 10'd2,    1'b0, 12'd360},
    '{1'b0, 10'd0,    1'b1, 12'd520},
    '{1'b0, 10'd3,    1'b0, 12'd680},
    '{1'b1, 10'd1,    1'b0, 12'd820},
    '{1'b0, 10'd5,    1'b0, 12'd980},
    '{1'b0, 10'd1023, 1'b0, 12'd1150}
  };

  pad_serial_read_controller_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .address        (address),
    .write_data     (write_data),
    .pad_buttons    (pad_buttons),
    .pad_status_bit (pad_status_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .interrupt_line (interrupt_line),
    .serial_busy    (serial_busy),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Zero bit period behaves as one tick
  function automatic logic [9:0] ticks_per_bit();
    return (cfg_period == 10'd0) ? 10'd1 : cfg_period;
  endfunction

  // Advance the controller state by one item and return its result
  function automatic pscr_pkg::result_t pad_ctl_step(pad_item_t it);
    pscr_pkg::result_t res;
    logic [15:0]       data_word;
    logic [3:0]        pos;
    res = '0;
    case (it.kind)
      pscr_pkg::KIND_TICK: begin
        if (tick_count != 10'd0) begin
          tick_count = tick_count - 10'd1;
          if (tick_count == 10'd0) begin
            pos = bit_pos[3:0];
            shift_word[pos] = pad_latched[pos];
            bit_pos = bit_pos + 5'd1;
            if (bit_pos < pscr_pkg::SERIAL_BITS) begin
              tick_count = ticks_per_bit();
            end else if (!ctl_word[pscr_pkg::CTL_INHIBIT_BIT]) begin
              irq_level = 1'b1;
            end
          end
        end
      end
      pscr_pkg::KIND_READ: begin
        data_word = cfg_instant ? pad_live : shift_word;
        case (it.address)
          pscr_pkg::ADDR_LOW:  res.read_data = data_word[7:0];
          pscr_pkg::ADDR_HIGH: res.read_data = data_word[15:8];
          pscr_pkg::ADDR_CTL:  res.read_data = ctl_word | pscr_pkg::CTL_FIXED |
                                 ((tick_count != 10'd0) ?
                                  (8'd1 << pscr_pkg::CTL_BUSY_BIT) : 8'd0);
          default:             res.read_data = 8'd0;
        endcase
      end
      pscr_pkg::KIND_WRITE: begin
        if (it.address == pscr_pkg::ADDR_CTL) begin
          if (it.write_data[pscr_pkg::CTL_START_BIT] &&
              !ctl_word[pscr_pkg::CTL_ABORT_BIT] && tick_count == 10'd0) begin
            pad_latched = pad_live;
            bit_pos = 5'd0;
            tick_count = ticks_per_bit();
          end
          if (it.write_data[pscr_pkg::CTL_ABORT_BIT]) begin
            tick_count = 10'd0;
            bit_pos = 5'd0;
          end
          if (it.write_data[pscr_pkg::CTL_INHIBIT_BIT]) irq_level = 1'b0;
          ctl_word = it.write_data & pscr_pkg::CTL_KEEP;
        end
      end
      default: begin
        pad_live = {it.pad_buttons, 1'b1, it.pad_status_bit};
      end
    endcase
    res.interrupt_line = irq_level;
    res.serial_busy = (tick_count != 10'd0);
    return res;
  endfunction

  function automatic pad_item_t make_item(logic [1:0] k, logic [7:0] a, logic [7:0] d);
    return '{k, a, d, 14'($urandom), 1'($urandom)};
  endfunction

  function automatic logic [7:0] bus_addr();
    case ($urandom_range(2))
      0:       return pscr_pkg::ADDR_LOW;
      1:       return pscr_pkg::ADDR_HIGH;
      default: return pscr_pkg::ADDR_CTL;
    endcase
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Offer one item, hold it until transfer, then predict its result
  task automatic send_item(input pad_item_t it, input logic typed = 1'b0,
                           input pscr_pkg::result_t want = '0);
    if (!quiet_run && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= it.kind;
    address        <= it.address;
    write_data     <= it.write_data;
    pad_buttons    <= it.pad_buttons;
    pad_status_bit <= it.pad_status_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (typed) begin
      void'(pad_ctl_step(it));
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(pad_ctl_step(it));
    end
  endtask

  // Drain, then rewrite both registers
  task automatic set_config(input logic instant, input logic [9:0] period);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pscr_pkg::CFG_INSTANT_READ;
    cfg_data  <= {9'd0, instant};
    @(posedge clk);
    cfg_index <= pscr_pkg::CFG_BIT_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_instant = instant;
    cfg_period  = period;
  endtask

  // Clear abort, start a read, tick it with reads, samples and a random abort mixed in
  task automatic run_serial_read();
    int n_ticks;
    int abort_at;
    int r;
    n_ticks = 16 * ticks_per_bit() + $urandom_range(0, 2);
    if (n_ticks > LONG_TICKS) n_ticks = LONG_TICKS;
    abort_at = ($urandom_range(99) < 15) ? $urandom_range(n_ticks - 1) : -1;
    if ($urandom_range(1)) send_item(make_item(pscr_pkg::KIND_SAMPLE, 8'd0, 8'd0));
    send_item(make_item(pscr_pkg::KIND_WRITE, pscr_pkg::ADDR_CTL,
                        8'($urandom) & pscr_pkg::CTL_KEEP & 8'hFE));
    send_item(make_item(pscr_pkg::KIND_WRITE, pscr_pkg::ADDR_CTL,
                        (8'($urandom) & pscr_pkg::CTL_KEEP & 8'hFE) |
                        (8'd1 << pscr_pkg::CTL_START_BIT)));
    for (int i = 0; i < n_ticks; i++) begin
      r = $urandom_range(99);
      if (r < 8) send_item(make_item(pscr_pkg::KIND_READ, bus_addr(), 8'($urandom)));
      else if (r < 11)
        send_item(make_item(pscr_pkg::KIND_SAMPLE, 8'($urandom), 8'($urandom)));
      if (i == abort_at)
        send_item(make_item(pscr_pkg::KIND_WRITE, pscr_pkg::ADDR_CTL,
                            8'($urandom) | (8'd1 << pscr_pkg::CTL_ABORT_BIT)));
      send_item(make_item(pscr_pkg::KIND_TICK, 8'($urandom), 8'($urandom)));
    end
    send_item(make_item(pscr_pkg::KIND_READ, pscr_pkg::ADDR_LOW, 8'd0));
    send_item(make_item(pscr_pkg::KIND_READ, pscr_pkg::ADDR_HIGH, 8'd0));
    send_item(make_item(pscr_pkg::KIND_READ, pscr_pkg::ADDR_CTL, 8'd0));
  endtask

  // Stimulus
  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    kind           <= pscr_pkg::KIND_TICK;
    address        <= 8'd0;
    write_data     <= 8'd0;
    pad_buttons    <= 14'd0;
    pad_status_bit <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= pscr_pkg::CFG_INSTANT_READ;
    cfg_data       <= 10'd0;
    pad_live    = '0;
    pad_latched = '0;
    shift_word  = '0;
    ctl_word    = '0;
    bit_pos     = '0;
    tick_count  = '0;
    irq_level   = 1'b0;
    cfg_instant = pscr_pkg::INSTANT_READ_RESET;
    cfg_period  = pscr_pkg::BIT_PERIOD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_tab[row]) begin
      if (dir_tab[row].is_cfg)
        set_config(dir_tab[row].item.pad_status_bit, dir_tab[row].item.pad_buttons[9:0]);
      else
        repeat (dir_tab[row].reps)
          send_item(dir_tab[row].item, dir_tab[row].typed, dir_tab[row].want);
    end

    // Random serial reads and noise, one register setting per phase
    foreach (phases[ph]) begin
      set_config(phases[ph].instant, phases[ph].period);
      quiet_run = phases[ph].quiet;
      while (items_sent < phases[ph].count) begin
        if ($urandom_range(99) < 75) begin
          run_serial_read();
        end else begin
          send_item(make_item(2'($urandom), $urandom_range(1) ? bus_addr() : 8'($urandom),
                              8'($urandom)));
        end
      end
    end
    quiet_run = 1'b0;

    // Drain and settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random back-pressure plus one long hold-off to fill the block
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!rx_hold_done && results_seen >= HOLD_AT) begin
        rx_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet_run || ($urandom_range(99) >= 20);
      @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %h %b %b",
                 $time, read_data, interrupt_line, serial_busy);
        mismatches++;
      end else begin
        check_field("read_data", pending_results[0].read_data, read_data);
        check_field("interrupt_line", {7'd0, pending_results[0].interrupt_line},
                    {7'd0, interrupt_line});
        check_field("serial_busy", {7'd0, pending_results[0].serial_busy},
                    {7'd0, serial_busy});
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
